FILE: hw/rtl/vhp_pkg.sv
package vhp_pkg;

  localparam int DATA_BITS          = 8;
  localparam int ADDR_OUT_BITS      = 14;
  localparam int VRAM_ADDR_BITS_DEF = 14;
  localparam int REG_COUNT          = 8;
  localparam int REG_IDX_BITS       = 3;
  localparam int CMD_Q_DEPTH        = 2;
  localparam int OUT_Q_DEPTH        = 4;

  typedef enum logic [1:0] {
    KIND_CTRL  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  // request handed from the front end to the memory side
  typedef struct packed {
    logic                      mem_we;
    logic                      mem_re;
    logic [ADDR_OUT_BITS-1:0]  mem_addr;
    logic [DATA_BITS-1:0]      wr_data;
    logic                      reg_written;
    logic [REG_IDX_BITS-1:0]   reg_index;
    logic [DATA_BITS-1:0]      reg_value;
    logic [ADDR_OUT_BITS-1:0]  address_now;
  } cmd_t;

  typedef struct packed {
    logic [DATA_BITS-1:0]      read_data;
    logic                      reg_written;
    logic [REG_IDX_BITS-1:0]   reg_index;
    logic [DATA_BITS-1:0]      reg_value;
    logic [ADDR_OUT_BITS-1:0]  address_now;
  } result_t;

endpackage

FILE: hw/rtl/vdp_host_port_vram_access.sv
// Path: request queue, result stage, result queue; the queue head drives the out_ ports.
// One request per cycle while the result queue has room; the video memory has one port.
// The front end takes a request whenever its two-entry request queue has room.
// Reset (rst_n low, synchronous) clears the control-pair state, the pointer and both queues.
// Video memory is not cleared by reset.
module vdp_host_port_vram_access #(
  parameter int VRAM_ADDR_BITS = vhp_pkg::VRAM_ADDR_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic [1:0]                        in_kind,
  input  logic [vhp_pkg::DATA_BITS-1:0]     in_data_byte,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic [vhp_pkg::DATA_BITS-1:0]     out_read_data,
  output logic                              out_reg_written,
  output logic [vhp_pkg::REG_IDX_BITS-1:0]  out_reg_index,
  output logic [vhp_pkg::DATA_BITS-1:0]     out_reg_value,
  output logic [vhp_pkg::ADDR_OUT_BITS-1:0] out_address_now
);

  import vhp_pkg::*;

  localparam int CMD_W = $bits(cmd_t);
  localparam int RES_W = $bits(result_t);

  logic                           fe_push;
  cmd_t                           fe_cmd;
  logic                           cmd_full;
  logic                           cmd_empty;
  logic                           cmd_pop;
  logic [CMD_W-1:0]               cmd_bits;
  cmd_t                           be_cmd;
  logic [$clog2(CMD_Q_DEPTH):0]   cmd_count;
  logic                           res_push;
  result_t                        be_res;
  logic                           res_full;
  logic [$clog2(OUT_Q_DEPTH):0]   res_count;
  logic [RES_W-1:0]               res_bits;
  result_t                        out_res;

  vhp_front #(
    .VRAM_ADDR_BITS (VRAM_ADDR_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_kind      (in_kind),
    .in_data_byte (in_data_byte),
    .cmd_push     (fe_push),
    .cmd          (fe_cmd),
    .cmd_full     (cmd_full)
  );

  vhp_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_Q_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fe_push),
    .wdata (fe_cmd),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_bits),
    .empty (cmd_empty),
    .count (cmd_count)
  );

  assign be_cmd = cmd_t'(cmd_bits);

  vhp_back #(
    .VRAM_ADDR_BITS (VRAM_ADDR_BITS),
    .OUT_DEPTH      (OUT_Q_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd       (be_cmd),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push),
    .res       (be_res),
    .res_full  (res_full),
    .res_count (res_count)
  );

  vhp_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUT_Q_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (be_res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_bits),
    .empty (out_empty),
    .count (res_count)
  );

  assign out_res         = result_t'(res_bits);
  assign out_read_data   = out_res.read_data;
  assign out_reg_written = out_res.reg_written;
  assign out_reg_index   = out_res.reg_index;
  assign out_reg_value   = out_res.reg_value;
  assign out_address_now = out_res.address_now;

`ifndef NO_ASSERTIONS
  a_cmd_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_full |-> (cmd_count != '0))
    else $error("request queue full with no entries");

  a_front_stalls_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_full |-> in_full)
    else $error("front end accepts while request queue is full");

  a_in_full_follows_queue: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> cmd_full)
    else $error("front end stalls while request queue has room");
`endif

endmodule

FILE: hw/rtl/vhp_ram.sv
module vhp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/vhp_fifo.sv
module vhp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  output logic                       full,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic [$clog2(DEPTH):0]     count
);

  localparam int PTR_BITS = $clog2(DEPTH);
  localparam int CNT_BITS = PTR_BITS + 1;

  logic [WIDTH-1:0]    store_r [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic                do_push, do_pop;

  assign full    = (count_r == CNT_BITS'(DEPTH));
  assign empty   = (count_r == '0);
  assign count   = count_r;
  assign rdata   = store_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

FILE: hw/rtl/vhp_front.sv
module vhp_front #(
  parameter int VRAM_ADDR_BITS = vhp_pkg::VRAM_ADDR_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [1:0]                    in_kind,
  input  logic [vhp_pkg::DATA_BITS-1:0] in_data_byte,
  output logic                          cmd_push,
  output vhp_pkg::cmd_t                 cmd,
  input  logic                          cmd_full
);

  import vhp_pkg::*;

  logic                      second_r, second_nxt;
  logic [DATA_BITS-1:0]      held_r, held_nxt;
  logic [VRAM_ADDR_BITS-1:0] ptr_r, ptr_nxt;
  logic [VRAM_ADDR_BITS-1:0] ptr_inc;
  logic                      accept;
  kind_t                     kind;

  assign kind     = kind_t'(in_kind);
  assign accept   = in_push && !cmd_full;
  assign in_full  = cmd_full;
  assign cmd_push = accept;
  assign ptr_inc  = ptr_r + 1'b1;

  always_comb begin
    second_nxt      = second_r;
    held_nxt        = held_r;
    ptr_nxt         = ptr_r;
    cmd             = '0;
    cmd.mem_addr    = ADDR_OUT_BITS'(ptr_r);
    cmd.wr_data     = in_data_byte;
    unique case (kind)
      KIND_CTRL: begin
        if (!second_r) begin
          held_nxt   = in_data_byte;
          second_nxt = 1'b1;
        end else begin
          second_nxt = 1'b0;
          if (in_data_byte[7]) begin
            cmd.reg_written = 1'b1;
            cmd.reg_index   = in_data_byte[REG_IDX_BITS-1:0] & REG_IDX_BITS'(REG_COUNT - 1);
            cmd.reg_value   = held_r;
          end else begin
            ptr_nxt = VRAM_ADDR_BITS'({in_data_byte[5:0], held_r});
          end
        end
      end
      KIND_WRITE: begin
        second_nxt = 1'b0;
        cmd.mem_we = 1'b1;
        ptr_nxt    = ptr_inc;
      end
      KIND_READ: begin
        second_nxt = 1'b0;
        cmd.mem_re = 1'b1;
        ptr_nxt    = ptr_inc;
      end
      KIND_NONE: begin
      end
    endcase
    cmd.address_now = ADDR_OUT_BITS'(ptr_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      second_r <= 1'b0;
      held_r   <= '0;
      ptr_r    <= '0;
    end else if (accept) begin
      second_r <= second_nxt;
      held_r   <= held_nxt;
      ptr_r    <= ptr_nxt;
    end
  end

endmodule

FILE: hw/rtl/vhp_back.sv
module vhp_back #(
  parameter int VRAM_ADDR_BITS = vhp_pkg::VRAM_ADDR_BITS_DEF,
  parameter int OUT_DEPTH      = vhp_pkg::OUT_Q_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cmd_empty,
  input  vhp_pkg::cmd_t              cmd,
  output logic                       cmd_pop,
  output logic                       res_push,
  output vhp_pkg::result_t           res,
  input  logic                       res_full,
  input  logic [$clog2(OUT_DEPTH):0] res_count
);

  import vhp_pkg::*;

  localparam int CNT_BITS = $clog2(OUT_DEPTH) + 1;

  logic                 issue;
  logic [CNT_BITS:0]    in_flight;
  logic                 s1_valid_r;
  cmd_t                 s1_r;
  logic [DATA_BITS-1:0] ram_rdata;

  // room in the result queue for everything already past the memory
  assign in_flight = (CNT_BITS + 1)'(res_count) + (CNT_BITS + 1)'(s1_valid_r);
  assign issue     = !cmd_empty && (in_flight < (CNT_BITS + 1)'(OUT_DEPTH));
  assign cmd_pop   = issue;

  vhp_ram #(
    .WIDTH (DATA_BITS),
    .DEPTH (1 << VRAM_ADDR_BITS)
  ) u_vram (
    .clk   (clk),
    .we    (issue && cmd.mem_we),
    .re    (issue && cmd.mem_re),
    .addr  (cmd.mem_addr[VRAM_ADDR_BITS-1:0]),
    .wdata (cmd.wr_data),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_r <= cmd;
    end
  end

  always_comb begin
    res_push        = s1_valid_r;
    res.read_data   = s1_r.mem_re ? ram_rdata : '0;
    res.reg_written = s1_r.reg_written;
    res.reg_index   = s1_r.reg_index;
    res.reg_value   = s1_r.reg_value;
    res.address_now = s1_r.address_now;
  end

`ifndef NO_ASSERTIONS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> !res_full)
    else $error("result pushed into a full queue");

  a_one_mem_op: assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> !(cmd.mem_we && cmd.mem_re))
    else $error("request both reads and writes memory");

  a_stage_follows_issue: assert property (@(posedge clk) disable iff (!rst_n)
    issue |=> s1_valid_r)
    else $error("issued request lost before result stage");

  a_reg_not_mem: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_r.reg_written |-> !s1_r.mem_we && !s1_r.mem_re)
    else $error("register write also touches memory");
`endif

endmodule
